// ===== rtl/gcm_pkg.sv =====
// Shared types and constants for the greedy coin change block.
// Used by gcm_div and greedy_change_maker; depends on nothing else.
package gcm_pkg;

    // Field widths
    localparam int AMT_W     = 20;
    localparam int COIN_W    = 16;
    localparam int CNT_W     = 20;
    localparam int IDX_OUT_W = 3;
    localparam int USE_W     = 3;
    localparam int REG_IDX_W = 3;

    // Number of coin slots and how many of them are configurable
    localparam int MAX_COINS     = 6;
    localparam int NUM_COIN_REGS = 6;
    localparam int IDX_W         = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

    // Divider step counter width: one quotient bit per step
    localparam int STEP_W = $clog2(AMT_W);

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_COINS_IN_USE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;

    // Reset value of coins_in_use
    localparam logic [USE_W-1:0] COINS_IN_USE_RESET = 3'd6;

    // Request to the shared divider
    typedef struct packed {
        logic              go;
        logic [AMT_W-1:0]  dividend;
        logic [COIN_W-1:0] divisor;
    } div_req_t;

    // Response from the shared divider
    typedef struct packed {
        logic              done;
        logic [AMT_W-1:0]  quotient;
        logic [COIN_W-1:0] remainder;
    } div_rsp_t;

    // Reset values of the coin registers, largest coin first
    function automatic logic [COIN_W-1:0] default_coin(input int i);
        logic [COIN_W-1:0] v;
        begin
            unique case (i)
                0:       v = 16'd200;
                1:       v = 16'd100;
                2:       v = 16'd50;
                3:       v = 16'd20;
                4:       v = 16'd5;
                default: v = 16'd1;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/gcm_div.sv =====
// Bit-serial restoring divider shared by all coin slots of the change maker.
// Depends on gcm_pkg for widths and the request and response structs.
module gcm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gcm_pkg::div_req_t req,
    output gcm_pkg::div_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [gcm_pkg::STEP_W-1:0]       step_reg;
    logic [gcm_pkg::AMT_W-1:0]        dq_reg;
    logic [gcm_pkg::COIN_W-1:0]       rem_reg;
    logic [gcm_pkg::COIN_W-1:0]       div_reg;

    logic [gcm_pkg::COIN_W:0]         trial;
    logic                             fits;
    logic [gcm_pkg::COIN_W:0]         diff;
    logic [gcm_pkg::COIN_W-1:0]       rem_next;

    // One step: bring down the next dividend bit and try a subtraction.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[gcm_pkg::AMT_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[gcm_pkg::COIN_W-1:0] : trial[gcm_pkg::COIN_W-1:0];
    end

    // Control state; the dividend register collects quotient bits at its bottom.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == gcm_pkg::STEP_W'(gcm_pkg::AMT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[gcm_pkg::AMT_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/greedy_change_maker.sv =====
// Greedy coin change: splits an amount in cents over the configured coin values.
// Each nonzero coin in use takes one division on the 20-step shared divider, a zero coin
// none; a check of the remainder follows, then the results, one per cycle. A new amount is
// taken only once the block is idle again after the last result of the previous one.
// Reset (rst_n, asynchronous, active low) restores coins 200..1 cents with six in use.
// Depends on gcm_pkg and gcm_div; results are one-cycle strobes that cannot be stalled.
module greedy_change_maker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gcm_pkg::AMT_W-1:0]         amount_cents,
    output logic                              result_valid,
    output logic [gcm_pkg::IDX_OUT_W-1:0]     coin_index,
    output logic [gcm_pkg::CNT_W-1:0]         coin_count,
    output logic                              no_solution,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcm_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [gcm_pkg::COIN_W-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT_DIV,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t                            state_reg;
    logic [gcm_pkg::USE_W-1:0]         coins_in_use_reg;
    logic [gcm_pkg::COIN_W-1:0]        coin_value_reg [gcm_pkg::NUM_COIN_REGS];
    logic [gcm_pkg::CNT_W-1:0]         counts_reg [gcm_pkg::MAX_COINS];
    logic [gcm_pkg::AMT_W-1:0]         rem_reg;
    logic [gcm_pkg::IDX_W-1:0]         idx_reg;
    logic [gcm_pkg::IDX_W-1:0]         last_idx_reg;
    logic                              div_go_reg;
    logic                              result_valid_reg;
    logic [gcm_pkg::IDX_OUT_W-1:0]     coin_index_reg;
    logic [gcm_pkg::CNT_W-1:0]         coin_count_reg;
    logic                              no_solution_reg;
    logic                              last_reg;

    logic [gcm_pkg::COIN_W-1:0]        cur_coin;
    logic [gcm_pkg::IDX_W-1:0]         last_idx_next;
    gcm_pkg::div_req_t                 div_req;
    gcm_pkg::div_rsp_t                 div_rsp;

    // Shared divider
    gcm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.go       = div_go_reg;
    assign div_req.dividend = rem_reg;
    assign div_req.divisor  = cur_coin;

    // Coin value of the current slot; slots without a register are worth one cent.
    always_comb
    begin
        cur_coin = gcm_pkg::COIN_W'(1);
        for (int i = 0; i < gcm_pkg::NUM_COIN_REGS; i++)
        begin
            if (32'(idx_reg) == i)
            begin
                cur_coin = coin_value_reg[i];
            end
        end
    end

    // Index of the last coin in use, with the register clamped to the valid range.
    always_comb
    begin
        if (coins_in_use_reg == '0)
        begin
            last_idx_next = '0;
        end
        else if (32'(coins_in_use_reg) > gcm_pkg::MAX_COINS)
        begin
            last_idx_next = gcm_pkg::IDX_W'(gcm_pkg::MAX_COINS - 1);
        end
        else
        begin
            last_idx_next = gcm_pkg::IDX_W'(coins_in_use_reg - 1'b1);
        end
    end

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coins_in_use_reg <= gcm_pkg::COINS_IN_USE_RESET;
            for (int i = 0; i < gcm_pkg::NUM_COIN_REGS; i++)
            begin
                coin_value_reg[i] <= gcm_pkg::default_coin(i);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == gcm_pkg::REG_COINS_IN_USE)
            begin
                coins_in_use_reg <= cfg_data[gcm_pkg::USE_W-1:0];
            end
            for (int i = 0; i < gcm_pkg::NUM_COIN_REGS; i++)
            begin
                if (cfg_index == gcm_pkg::REG_IDX_W'(32'(gcm_pkg::REG_COIN_VALUE_0) + i))
                begin
                    coin_value_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Sequencer: one division per nonzero coin, then the check, then the results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            div_go_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            idx_reg          <= '0;
            last_idx_reg     <= '0;
        end
        else
        begin
            div_go_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg      <= amount_cents;
                        idx_reg      <= '0;
                        last_idx_reg <= last_idx_next;
                        state_reg    <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH:
                begin
                    if (cur_coin == '0)
                    begin
                        // A zero coin takes nothing and passes the remainder on.
                        counts_reg[idx_reg] <= '0;
                        if (idx_reg == last_idx_reg)
                        begin
                            state_reg <= ST_CHECK;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_WAIT_DIV;
                    end
                end
                ST_WAIT_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        counts_reg[idx_reg] <= div_rsp.quotient;
                        rem_reg <= gcm_pkg::AMT_W'(div_rsp.remainder);
                        if (idx_reg == last_idx_reg)
                        begin
                            state_reg <= ST_CHECK;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_LAUNCH;
                        end
                    end
                end
                ST_CHECK:
                begin
                    idx_reg <= '0;
                    if (rem_reg != '0)
                    begin
                        // Something is left over: a single no-solution result.
                        result_valid_reg <= 1'b1;
                        coin_index_reg   <= '0;
                        coin_count_reg   <= '0;
                        no_solution_reg  <= 1'b1;
                        last_reg         <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // One count per cycle, in register order.
                    result_valid_reg <= 1'b1;
                    coin_index_reg   <= gcm_pkg::IDX_OUT_W'(idx_reg);
                    coin_count_reg   <= counts_reg[idx_reg];
                    no_solution_reg  <= 1'b0;
                    last_reg         <= (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign coin_index   = coin_index_reg;
    assign coin_count   = coin_count_reg;
    assign no_solution  = no_solution_reg;
    assign last         = last_reg;

endmodule

// ===== bench/tb_greedy_change_maker.sv =====
// Self-checking testbench for greedy_change_maker: drives amounts and register writes,
// predicts the greedy coin split of every accepted amount and checks each result strobe.
// Depends on gcm_pkg and the greedy_change_maker RTL.
`timescale 1ns / 100ps

module tb_greedy_change_maker;

    import gcm_pkg::*;

    // A register index that maps to no register; writes to it must be dropped.
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 160;

    typedef enum logic [1:0] {OP_SPLIT, OP_WRITE, OP_SYNC} op_kind_t;

    typedef struct {
        op_kind_t             kind;
        logic [AMT_W-1:0]     amt;
        logic [REG_IDX_W-1:0] idx;
        logic [COIN_W-1:0]    data;
    } bench_op_t;

    typedef struct {
        logic [IDX_OUT_W-1:0] idx;
        logic [CNT_W-1:0]     count;
        logic                 no_sol;
        logic                 is_last;
    } coin_result_t;

    typedef enum logic [1:0] {DRV_PICK, DRV_SPLIT, DRV_HOLD, DRV_WRITE} drv_state_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [AMT_W-1:0]     amount_cents = '0;
    logic                 result_valid;
    logic [IDX_OUT_W-1:0] coin_index;
    logic [CNT_W-1:0]     coin_count;
    logic                 no_solution;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [COIN_W-1:0]    cfg_data = '0;

    // Pending stimulus and expected coin counts
    bench_op_t    ops [$];
    coin_result_t coin_split_q [$];
    int           results_due = 0;
    int           err_cnt = 0;
    logic         stim_done = 1'b0;

    // Shadow of the block's registers
    logic [USE_W-1:0]  coins_used = COINS_IN_USE_RESET;
    logic [COIN_W-1:0] coin_val [NUM_COIN_REGS] =
        '{16'd200, 16'd100, 16'd50, 16'd20, 16'd5, 16'd1};

    // Driver state
    drv_state_t drv_state = DRV_PICK;
    bench_op_t  cur_op;
    int         gap_left = 0;
    logic       gap_overlaps = 1'b0;
    int         settle_left = 0;

    greedy_change_maker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .amount_cents (amount_cents),
        .result_valid (result_valid),
        .coin_index   (coin_index),
        .coin_count   (coin_count),
        .no_solution  (no_solution),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Greedy split of one amount over the shadow coin set; returns the number of results.
    function automatic int greedy_split(input logic [AMT_W-1:0] amt);
        logic [AMT_W-1:0] rest;
        logic [CNT_W-1:0] cnt [MAX_COINS];
        int               used;
        coin_result_t     r;
        rest = amt;
        used = int'(coins_used);
        if (used < 1)
            used = 1;
        if (used > MAX_COINS)
            used = MAX_COINS;
        for (int i = 0; i < used; i++)
        begin
            if (coin_val[i] == '0)
                cnt[i] = '0;
            else
            begin
                cnt[i] = rest / coin_val[i];
                rest   = rest % coin_val[i];
            end
        end
        // A leftover remainder gives a single no-solution result.
        if (rest != '0)
        begin
            r = '{idx: '0, count: '0, no_sol: 1'b1, is_last: 1'b1};
            coin_split_q.insert(coin_split_q.size(), r);
            return 1;
        end
        for (int i = 0; i < used; i++)
        begin
            r = '{idx: IDX_OUT_W'(i), count: cnt[i], no_sol: 1'b0, is_last: (i == used - 1)};
            coin_split_q.insert(coin_split_q.size(), r);
        end
        return used;
    endfunction

    // Register write into the shadow copy; unmapped indexes are dropped.
    function automatic void apply_write(input logic [REG_IDX_W-1:0] idx,
                                        input logic [COIN_W-1:0] val);
        if (idx == REG_COINS_IN_USE)
            coins_used = val[USE_W-1:0];
        else if (idx >= REG_COIN_VALUE_0 && idx < REG_COIN_VALUE_0 + NUM_COIN_REGS)
            coin_val[idx - REG_COIN_VALUE_0] = val;
    endfunction

    task automatic queue_split(input logic [AMT_W-1:0] amt);
        bench_op_t op;
        op = '{kind: OP_SPLIT, amt: amt, idx: '0, data: '0};
        ops.insert(ops.size(), op);
    endtask

    task automatic queue_write(input logic [REG_IDX_W-1:0] idx, input logic [COIN_W-1:0] val);
        bench_op_t op;
        op = '{kind: OP_WRITE, amt: '0, idx: idx, data: val};
        ops.insert(ops.size(), op);
    endtask

    task automatic queue_sync();
        bench_op_t op;
        op = '{kind: OP_SYNC, amt: '0, idx: '0, data: '0};
        ops.insert(ops.size(), op);
    endtask

    // Driver: plays the pending queue; register writes and syncs wait for an idle block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            case (drv_state)
                DRV_PICK:
                begin
                    if (gap_left != 0)
                    begin
                        if (!busy || gap_overlaps)
                            gap_left <= gap_left - 1;
                    end
                    else if (ops.size() != 0)
                    begin
                        cur_op = ops.pop_front();
                        if (cur_op.kind == OP_SPLIT)
                        begin
                            start        <= 1'b1;
                            amount_cents <= cur_op.amt;
                            drv_state    <= DRV_SPLIT;
                        end
                        else
                        begin
                            settle_left <= SETTLE_CYCLES;
                            drv_state   <= DRV_HOLD;
                        end
                    end
                    else
                        stim_done <= 1'b1;
                end
                DRV_SPLIT:
                begin
                    // The amount transfers at this edge when the block is not busy.
                    if (!busy)
                    begin
                        start        <= 1'b0;
                        gap_left     <= $urandom_range(0, 6);
                        gap_overlaps <= ($urandom_range(0, 1) != 0);
                        drv_state    <= DRV_PICK;
                    end
                end
                DRV_HOLD:
                begin
                    if (results_due != 0 || busy)
                        settle_left <= SETTLE_CYCLES;
                    else if (settle_left != 0)
                        settle_left <= settle_left - 1;
                    else if (cur_op.kind == OP_WRITE)
                    begin
                        cfg_valid <= 1'b1;
                        cfg_index <= cur_op.idx;
                        cfg_data  <= cur_op.data;
                        drv_state <= DRV_WRITE;
                    end
                    else
                    begin
                        gap_left     <= $urandom_range(0, 6);
                        gap_overlaps <= ($urandom_range(0, 1) != 0);
                        drv_state    <= DRV_PICK;
                    end
                end
                default:
                begin
                    if (cfg_ready)
                    begin
                        cfg_valid    <= 1'b0;
                        gap_left     <= $urandom_range(0, 6);
                        gap_overlaps <= ($urandom_range(0, 1) != 0);
                        drv_state    <= DRV_PICK;
                    end
                end
            endcase
        end
    end

    // Monitor: checks each result strobe, then predicts any amount accepted at this edge.
    always @(posedge clk)
    begin : monitor
        coin_result_t want;
        int           n_pushed;
        int           n_popped;
        n_pushed = 0;
        n_popped = 0;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (coin_split_q.size() == 0)
                begin
                    $error("unexpected result: coin_index %0d coin_count %0d no_solution %0b",
                           coin_index, coin_count, no_solution);
                    err_cnt++;
                end
                else
                begin
                    want     = coin_split_q.pop_front();
                    n_popped = 1;
                    if (coin_index !== want.idx)
                    begin
                        $error("coin_index: expected %0d, actual %0d", want.idx, coin_index);
                        err_cnt++;
                    end
                    if (coin_count !== want.count)
                    begin
                        $error("coin_count: expected %0d, actual %0d", want.count, coin_count);
                        err_cnt++;
                    end
                    if (no_solution !== want.no_sol)
                    begin
                        $error("no_solution: expected %0b, actual %0b", want.no_sol, no_solution);
                        err_cnt++;
                    end
                    if (last !== want.is_last)
                    begin
                        $error("last: expected %0b, actual %0b", want.is_last, last);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy)
                n_pushed = greedy_split(amount_cents);
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            results_due <= results_due + n_pushed - n_popped;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : run_ctl
        logic [USE_W-1:0]  plan_used;
        logic [COIN_W-1:0] plan_val [NUM_COIN_REGS];
        int                eff;
        int                mode;
        int                pick;
        int unsigned       sum;

        // Default coin set: zero, extremes and alternating bit patterns.
        queue_split(20'd0);
        queue_split(20'd1);
        queue_split(20'hFFFFF);
        queue_split(20'd1000000);
        queue_split(20'd387);
        queue_split(20'hAAAAA);
        queue_split(20'h55555);
        queue_sync();

        // One coin in use: exact split and a leftover remainder.
        queue_write(REG_COIN_VALUE_0, 16'd7);
        queue_write(REG_COINS_IN_USE, 16'd1);
        queue_split(20'd14);
        queue_split(20'd15);

        // Zero coins in use behaves as one.
        queue_write(REG_COINS_IN_USE, 16'd0);
        queue_split(20'd21);
        queue_split(20'hFFFFF);

        // Coins in use above the maximum, a zero coin and the largest coin value.
        queue_write(REG_COINS_IN_USE, 16'd7);
        queue_write(REG_COIN_VALUE_0, 16'hFFFF);
        queue_write(REG_IDX_W'(REG_COIN_VALUE_0 + 1), 16'd0);
        queue_write(REG_IDX_W'(REG_COIN_VALUE_0 + 2), 16'd1000);
        queue_write(REG_IDX_W'(REG_COIN_VALUE_0 + 3), 16'd3);
        queue_write(REG_IDX_W'(REG_COIN_VALUE_0 + 4), 16'd2);
        queue_write(REG_IDX_W'(REG_COIN_VALUE_0 + 5), 16'hFFFF);
        queue_split(20'd132073);
        queue_split(20'hFFFFF);
        queue_split(20'd0);
        queue_split(20'd1);

        // A write to the unmapped index must change nothing.
        queue_write(REG_UNMAPPED, 16'hFFFF);
        queue_split(20'd5);

        // Two coins with a unit coin second.
        queue_write(REG_IDX_W'(REG_COIN_VALUE_0 + 1), 16'd1);
        queue_write(REG_COINS_IN_USE, 16'd2);
        queue_split(20'd65534);

        // Random phases, each with its own coin set.
        for (int ph = 0; ph < 8; ph++)
        begin
            queue_sync();
            pick = $urandom_range(0, 9);
            if (pick < 8)
                plan_used = USE_W'($urandom_range(1, 6));
            else if (pick == 8)
                plan_used = 3'd0;
            else
                plan_used = 3'd7;
            eff  = (plan_used == 0) ? 1 :
                   ((int'(plan_used) > MAX_COINS) ? MAX_COINS : int'(plan_used));
            mode = $urandom_range(0, 4);
            for (int k = 0; k < NUM_COIN_REGS; k++)
            begin
                case (mode)
                    0, 1:    plan_val[k] = (k == eff - 1) ? 16'd1 :
                                           COIN_W'($urandom_range(2, 2000));
                    2:       plan_val[k] = COIN_W'($urandom_range(1, 65535));
                    3:       plan_val[k] = COIN_W'($urandom_range(1, 40));
                    default: plan_val[k] = ($urandom_range(0, 2) == 0) ? 16'd0 :
                                           COIN_W'($urandom_range(1, 500));
                endcase
                queue_write(REG_IDX_W'(32'(REG_COIN_VALUE_0) + k), plan_val[k]);
            end
            if ($urandom_range(0, 3) == 0)
                queue_write(REG_UNMAPPED, COIN_W'($urandom_range(0, 65535)));
            queue_write(REG_COINS_IN_USE, COIN_W'(plan_used));

            for (int n = 0; n < 19; n++)
            begin
                // Now and then hold off until the block has delivered everything.
                if ($urandom_range(0, 14) == 0)
                    queue_sync();
                pick = $urandom_range(0, 9);
                if (pick < 4)
                begin
                    // Built from whole coins, so the split usually comes out exact.
                    sum = 0;
                    for (int k = 0; k < eff; k++)
                        sum += $urandom_range(0, 20) * plan_val[k];
                    queue_split(AMT_W'(sum));
                end
                else if (pick < 7)
                    queue_split(AMT_W'($urandom_range(0, 2000)));
                else
                    queue_split(AMT_W'($urandom_range(0, 20'hFFFFF)));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (!(stim_done && results_due == 0));
        repeat (TAIL_CYCLES) @(posedge clk);

        if (coin_split_q.size() != 0)
        begin
            $error("%0d expected results never arrived", coin_split_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(400_000 * 10);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
